>>> hw/rtl/rgb_offset_hsl_adjust_top_defines.svh
// Assertion macros for the RGB offset / HSL adjust block.
`ifndef RGB_OFFSET_HSL_ADJUST_TOP_DEFINES_SVH
`define RGB_OFFSET_HSL_ADJUST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RGBHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RGBHA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGBHA_ASSERT(lbl, prop, msg)
`define RGBHA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/rgbha_pkg.sv
`default_nettype none
package rgbha_pkg;

  localparam int CFG_AW = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_RED_OFF     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GREEN_OFF   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLUE_OFF    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HUE_SHIFT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SAT_SHIFT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_SHIFT = 3'd5;

  typedef struct packed {
    logic signed [8:0] red;
    logic signed [8:0] green;
    logic signed [8:0] blue;
  } offset_t;

endpackage
`default_nettype wire

>>> hw/rtl/rgbha_core.sv
`default_nettype none
`include "rgb_offset_hsl_adjust_top_defines.svh"
module rgbha_core #(
  parameter int CHANNEL_BITS = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [CHANNEL_BITS-1:0]    in_red,
  input  wire logic [CHANNEL_BITS-1:0]    in_green,
  input  wire logic [CHANNEL_BITS-1:0]    in_blue,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [CHANNEL_BITS-1:0]         out_red,
  output logic [CHANNEL_BITS-1:0]         out_green,
  output logic [CHANNEL_BITS-1:0]         out_blue,
  input  wire rgbha_pkg::offset_t         offs,
  input  wire logic signed [FRAC_BITS+1:0] hue_term,
  input  wire logic signed [FRAC_BITS+1:0] sat_term,
  input  wire logic signed [FRAC_BITS+1:0] light_term
);

  localparam int CB  = CHANNEL_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int SW  = ((CB > 8) ? CB : 8) + 3;
  localparam int DW  = CB + 3;
  localparam int QW  = FB + 1;
  localparam int PW  = FB + 4;
  localparam int RW  = FB + CB + 2;
  localparam int LPW = 2*CB + FB + 3;
  localparam int NST = FB + 9;
  localparam int SD0 = 2;
  localparam int SC  = FB + 3;
  localparam int SDM = FB + 4;
  localparam int SE  = FB + 5;
  localparam int SF  = FB + 6;
  localparam int SG  = FB + 7;
  localparam int SH  = FB + 8;

  localparam logic [CB-1:0] CMAX = '1;
  localparam logic [63:0] L_DEN = 64'({CMAX, 1'b0});
  localparam logic [RW-1:0] L_RCP =
    RW'(((64'd1 << (FB + 2*CB + 2)) + L_DEN - 64'd1) / L_DEN);
  localparam logic signed [PW-1:0] P_ONE   = PW'(64'd1 << FB);
  localparam logic signed [PW-1:0] P_TWO   = PW'(64'd2 << FB);
  localparam logic signed [PW-1:0] P_FOUR  = PW'(64'd4 << FB);
  localparam logic signed [PW-1:0] P_THIRD = PW'((64'd1 << FB) / 3);

  localparam logic [1:0] MODE_RISE = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd1;
  localparam logic [1:0] MODE_FALL = 2'd2;
  localparam logic [1:0] MODE_LOW  = 2'd3;

  logic [NST-1:0] v_r, v_nxt, en;

  assign en[NST-1] = ~v_r[NST-1] | out_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = ~v_r[k] | en[k+1];
  end

  assign v_nxt = (en & {v_r[NST-2:0], in_valid}) | (~en & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  // offset and clamp
  logic [CB-1:0]          a_in [0:2];
  logic signed [8:0]      a_off [0:2];
  logic signed [SW-1:0]   a_sum [0:2];
  logic [CB-1:0]          a_nxt [0:2];
  logic [CB-1:0]          a_r [0:2];

  assign a_in[0]  = in_red;
  assign a_in[1]  = in_green;
  assign a_in[2]  = in_blue;
  assign a_off[0] = offs.red;
  assign a_off[1] = offs.green;
  assign a_off[2] = offs.blue;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_sum[i] = $signed(SW'(a_in[i])) + SW'(a_off[i]);
      if (a_sum[i][SW-1]) begin
        a_nxt[i] = '0;
      end else if (a_sum[i][SW-2:0] > (SW-1)'(CMAX)) begin
        a_nxt[i] = CMAX;
      end else begin
        a_nxt[i] = a_sum[i][CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) a_r[i] <= a_nxt[i];
    end
  end

  // max/min, hue numerator and divisors, lightness by reciprocal
  logic [CB-1:0]  b_mx, b_mn, b_d;
  logic [CB:0]    b_sum;
  logic [DW-1:0]  b_d6;
  logic [LPW-1:0] b_lprod;
  logic [DW-1:0]  b_num_nxt [0:1], b_den_nxt [0:1];
  logic [DW-1:0]  b_num_r [0:1], b_den_r [0:1];
  logic           b_gray_r;
  logic [QW-1:0]  b_l_r;

  always_comb begin
    b_mx = a_r[0];
    b_mn = a_r[0];
    if (a_r[1] > b_mx) b_mx = a_r[1];
    if (a_r[2] > b_mx) b_mx = a_r[2];
    if (a_r[1] < b_mn) b_mn = a_r[1];
    if (a_r[2] < b_mn) b_mn = a_r[2];
    b_d   = b_mx - b_mn;
    b_sum = (CB+1)'(b_mx) + (CB+1)'(b_mn);
    b_d6  = (DW'(b_d) << 2) + (DW'(b_d) << 1);
    if (a_r[0] >= a_r[1] && a_r[0] >= a_r[2]) begin
      if (a_r[1] >= a_r[2]) begin
        b_num_nxt[0] = DW'(a_r[1]) - DW'(a_r[2]);
      end else begin
        b_num_nxt[0] = b_d6 - (DW'(a_r[2]) - DW'(a_r[1]));
      end
    end else if (a_r[1] >= a_r[2]) begin
      b_num_nxt[0] = ((DW'(b_d) << 1) + DW'(a_r[2])) - DW'(a_r[0]);
    end else begin
      b_num_nxt[0] = ((DW'(b_d) << 2) + DW'(a_r[0])) - DW'(a_r[1]);
    end
    b_den_nxt[0] = b_d6;
    b_num_nxt[1] = DW'(b_d);
    if (b_sum < (CB+1)'(CMAX)) begin
      b_den_nxt[1] = DW'(b_sum);
    end else begin
      b_den_nxt[1] = DW'({CMAX, 1'b0}) - DW'(b_sum);
    end
    b_lprod = LPW'(b_sum) * LPW'(L_RCP);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 2; i++) begin
        b_num_r[i] <= b_num_nxt[i];
        b_den_r[i] <= b_den_nxt[i];
      end
      b_gray_r <= (b_d == '0);
      b_l_r    <= b_lprod[LPW-1:2*CB+2];
    end
  end

  // restoring dividers, one quotient bit per stage; lanes: hue, sat
  logic [DW-1:0] dv_rem_r [0:FB][0:1];
  logic [DW-1:0] dv_den_r [0:FB][0:1];
  logic [QW-1:0] dv_quo_r [0:FB][0:1];
  logic          dv_gray_r [0:FB];
  logic [QW-1:0] dv_l_r [0:FB];

  for (genvar k = 0; k <= FB; k++) begin : g_div
    logic [DW-1:0] rem_in [0:1];
    logic [DW-1:0] den_in [0:1];
    logic [QW-1:0] quo_in [0:1];
    logic          gray_in;
    logic [QW-1:0] l_in;
    logic [DW:0]   shf [0:1];
    logic          ge [0:1];
    logic [DW-1:0] rem_nxt [0:1];
    logic [QW-1:0] quo_nxt [0:1];

    if (k == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 2; i++) begin
          rem_in[i] = b_num_r[i];
          den_in[i] = b_den_r[i];
          quo_in[i] = '0;
        end
      end
      assign gray_in = b_gray_r;
      assign l_in    = b_l_r;
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < 2; i++) begin
          rem_in[i] = dv_rem_r[k-1][i];
          den_in[i] = dv_den_r[k-1][i];
          quo_in[i] = dv_quo_r[k-1][i];
        end
      end
      assign gray_in = dv_gray_r[k-1];
      assign l_in    = dv_l_r[k-1];
    end

    always_comb begin
      for (int i = 0; i < 2; i++) begin
        shf[i] = (k == 0) ? {1'b0, rem_in[i]} : {rem_in[i], 1'b0};
        ge[i]  = (shf[i] >= {1'b0, den_in[i]});
        rem_nxt[i] = ge[i] ? DW'(shf[i] - {1'b0, den_in[i]}) : DW'(shf[i]);
        quo_nxt[i] = {quo_in[i][QW-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (en[SD0+k]) begin
        for (int i = 0; i < 2; i++) begin
          dv_rem_r[k][i] <= rem_nxt[i];
          dv_den_r[k][i] <= den_in[i];
          dv_quo_r[k][i] <= quo_nxt[i];
        end
        dv_gray_r[k] <= gray_in;
        dv_l_r[k]    <= l_in;
      end
    end
  end

  // apply shifts: wrap hue, clamp saturation and lightness
  logic [QW-1:0]        c_h_in, c_s_in;
  logic signed [PW-1:0] c_hv, c_hv1, c_hv2, c_sv, c_lv;
  logic [QW-1:0]        c_s_nxt, c_l_nxt;
  logic [QW-1:0]        c_h_r, c_s_r, c_l_r;

  always_comb begin
    c_h_in = dv_gray_r[FB] ? '0 : dv_quo_r[FB][0];
    c_s_in = dv_gray_r[FB] ? '0 : dv_quo_r[FB][1];
    c_hv  = $signed(PW'(c_h_in)) + PW'(hue_term);
    c_hv1 = (c_hv <= 0) ? c_hv + P_ONE : ((c_hv > P_ONE) ? c_hv - P_ONE : c_hv);
    c_hv2 = (c_hv1 <= 0) ? c_hv1 + P_ONE : ((c_hv1 > P_ONE) ? c_hv1 - P_ONE : c_hv1);
    c_sv  = $signed(PW'(c_s_in)) + PW'(sat_term);
    c_lv  = $signed(PW'(dv_l_r[FB])) + PW'(light_term);
    if (c_sv < 0) begin
      c_s_nxt = '0;
    end else if (c_sv > P_ONE) begin
      c_s_nxt = P_ONE[QW-1:0];
    end else begin
      c_s_nxt = c_sv[QW-1:0];
    end
    if (c_lv < 0) begin
      c_l_nxt = '0;
    end else if (c_lv > P_ONE) begin
      c_l_nxt = P_ONE[QW-1:0];
    end else begin
      c_l_nxt = c_lv[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[SC]) begin
      c_h_r <= c_hv2[QW-1:0];
      c_s_r <= c_s_nxt;
      c_l_r <= c_l_nxt;
    end
  end

  // l*s product
  logic [2*FB+1:0] d_prod;
  logic [QW-1:0]   d_h_r, d_s_r, d_l_r, d_m_r;

  assign d_prod = c_l_r * c_s_r;

  always_ff @(posedge clk) begin
    if (en[SDM]) begin
      d_h_r <= c_h_r;
      d_s_r <= c_s_r;
      d_l_r <= c_l_r;
      d_m_r <= d_prod[2*FB:FB];
    end
  end

  // q, p and per-channel hue segment
  logic signed [PW-1:0] e_h, e_s, e_l, e_m, e_q, e_p, e_dv;
  logic signed [PW-1:0] e_t [0:2];
  logic signed [PW-1:0] e_t6 [0:2];
  logic signed [PW-1:0] e_fv [0:2];
  logic [1:0]           e_mode_nxt [0:2];
  logic signed [PW-1:0] e_p_r, e_q_r;
  logic [FB+1:0]        e_diff_r;
  logic [QW-1:0]        e_f_r [0:2];
  logic [1:0]           e_mode_r [0:2];

  always_comb begin
    e_h = PW'(d_h_r);
    e_s = PW'(d_s_r);
    e_l = PW'(d_l_r);
    e_m = PW'(d_m_r);
    e_q = ((e_l <<< 1) < P_ONE) ? e_l + e_m : e_l + e_s - e_m;
    e_p = (e_l <<< 1) - e_q;
    e_dv = (e_q > e_p) ? e_q - e_p : '0;
    e_t[0] = e_h + P_THIRD;
    e_t[1] = e_h;
    e_t[2] = e_h - P_THIRD;
    for (int i = 0; i < 3; i++) begin
      if (e_t[i] > P_ONE) e_t[i] = e_t[i] - P_ONE;
      if (e_t[i] <= 0) e_t[i] = e_t[i] + P_ONE;
      e_t6[i] = (e_t[i] <<< 2) + (e_t[i] <<< 1);
      if (e_t6[i] < P_ONE) begin
        e_mode_nxt[i] = MODE_RISE;
        e_fv[i] = e_t6[i];
      end else if ((e_t[i] <<< 1) < P_ONE) begin
        e_mode_nxt[i] = MODE_HIGH;
        e_fv[i] = '0;
      end else if (e_t[i] + (e_t[i] <<< 1) < P_TWO) begin
        e_mode_nxt[i] = MODE_FALL;
        e_fv[i] = P_FOUR - e_t6[i];
      end else begin
        e_mode_nxt[i] = MODE_LOW;
        e_fv[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[SE]) begin
      e_p_r    <= e_p;
      e_q_r    <= e_q;
      e_diff_r <= e_dv[FB+1:0];
      for (int i = 0; i < 3; i++) begin
        e_f_r[i]    <= e_fv[i][QW-1:0];
        e_mode_r[i] <= e_mode_nxt[i];
      end
    end
  end

  // ramp products
  logic [2*FB+2:0]      f_prod [0:2];
  logic [FB+2:0]        f_add_r [0:2];
  logic [1:0]           f_mode_r [0:2];
  logic signed [PW-1:0] f_p_r, f_q_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_prod[i] = (2*FB+3)'(e_diff_r) * (2*FB+3)'(e_f_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[SF]) begin
      f_p_r <= e_p_r;
      f_q_r <= e_q_r;
      for (int i = 0; i < 3; i++) begin
        f_add_r[i]  <= f_prod[i][2*FB+2:FB];
        f_mode_r[i] <= e_mode_r[i];
      end
    end
  end

  // channel value, clamped
  logic signed [PW-1:0] g_cv [0:2];
  logic [QW-1:0]        g_c_nxt [0:2];
  logic [QW-1:0]        g_c_r [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (f_mode_r[i]) inside
        MODE_RISE, MODE_FALL: g_cv[i] = f_p_r + PW'(f_add_r[i]);
        MODE_HIGH:            g_cv[i] = f_q_r;
        default:              g_cv[i] = f_p_r;
      endcase
      if (g_cv[i] < 0) begin
        g_c_nxt[i] = '0;
      end else if (g_cv[i] > P_ONE) begin
        g_c_nxt[i] = P_ONE[QW-1:0];
      end else begin
        g_c_nxt[i] = g_cv[i][QW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[SG]) begin
      for (int i = 0; i < 3; i++) g_c_r[i] <= g_c_nxt[i];
    end
  end

  // scale to channel range
  logic [QW+CB-1:0] h_scaled [0:2];
  logic [CB-1:0]    h_out_r [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_scaled[i] = {g_c_r[i], {CB{1'b0}}} - (QW+CB)'(g_c_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[SH]) begin
      for (int i = 0; i < 3; i++) h_out_r[i] <= h_scaled[i][FB+CB-1:FB];
    end
  end

  assign out_red   = h_out_r[0];
  assign out_green = h_out_r[1];
  assign out_blue  = h_out_r[2];

  `RGBHA_ASSERT(a_out_hold, v_r[NST-1] && !out_ready |=> v_r[NST-1] && $stable(out_red)
    && $stable(out_green) && $stable(out_blue), "result word dropped or changed under stall")
  `RGBHA_ASSERT(a_quo_range, v_r[SC-1] && !dv_gray_r[FB] |-> dv_quo_r[FB][0] < P_ONE[QW-1:0]
    && dv_quo_r[FB][1] <= P_ONE[QW-1:0], "hue or saturation quotient out of range")
  `RGBHA_ASSERT(a_hue_wrap, v_r[SC] |-> c_h_r != '0 && c_h_r <= P_ONE[QW-1:0],
    "wrapped hue outside (0,1]")
  `RGBHA_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> v_r == '0, "pipeline not empty after reset")

endmodule
`default_nettype wire

>>> hw/rtl/rgb_offset_hsl_adjust_top.sv
`default_nettype none
// Pixel color adjuster. Each input word carries one RGB pixel; a signed offset
// is added per channel (clamped), the pixel goes to HSL, the hue, saturation and
// lightness shifts are applied, and the pixel returns to RGB. One pixel is taken
// per clock with no bubbles while the output is not stalled; the pipeline holds
// two dividers that produce one quotient bit per pipeline stage. Each
// stage advances independently, so a stalled output does not block input while
// the pipeline has empty slots. Write registers only with the pipeline drained;
// shift registers take effect once their registered scaled terms have updated.
module rgb_offset_hsl_adjust_top #(
  parameter int CHANNEL_BITS = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // red, green, blue
  input  wire logic [((3*CHANNEL_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // red, green, blue
  output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]         out_tdata,
  input  wire logic                                   cfg_psel,
  input  wire logic                                   cfg_penable,
  input  wire logic                                   cfg_pwrite,
  input  wire logic [rgbha_pkg::CFG_AW-1:0]           cfg_paddr,
  input  wire logic [31:0]                            cfg_pwdata,
  output logic [31:0]                                 cfg_prdata,
  output logic                                        cfg_pready
);

  localparam int CB  = CHANNEL_BITS;
  localparam int KSH = 14;
  localparam int TW  = FRAC_BITS + 2;
  localparam logic [FRAC_BITS+7:0] HK =
    (FRAC_BITS+8)'(((64'd1 << (FRAC_BITS + KSH)) + 64'd99) / 64'd100);

  rgbha_pkg::offset_t             off_r;
  logic signed [7:0]              hue_r, sat_r, light_r;
  logic                           wr_en;
  logic [rgbha_pkg::REG_IDX_W-1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      hue_r   <= '0;
      sat_r   <= '0;
      light_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        rgbha_pkg::REG_RED_OFF:     off_r.red   <= cfg_pwdata[8:0];
        rgbha_pkg::REG_GREEN_OFF:   off_r.green <= cfg_pwdata[8:0];
        rgbha_pkg::REG_BLUE_OFF:    off_r.blue  <= cfg_pwdata[8:0];
        rgbha_pkg::REG_HUE_SHIFT:   hue_r       <= cfg_pwdata[7:0];
        rgbha_pkg::REG_SAT_SHIFT:   sat_r       <= cfg_pwdata[7:0];
        rgbha_pkg::REG_LIGHT_SHIFT: light_r     <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rgbha_pkg::REG_RED_OFF:     cfg_prdata = {23'b0, off_r.red};
      rgbha_pkg::REG_GREEN_OFF:   cfg_prdata = {23'b0, off_r.green};
      rgbha_pkg::REG_BLUE_OFF:    cfg_prdata = {23'b0, off_r.blue};
      rgbha_pkg::REG_HUE_SHIFT:   cfg_prdata = {24'b0, hue_r};
      rgbha_pkg::REG_SAT_SHIFT:   cfg_prdata = {24'b0, sat_r};
      rgbha_pkg::REG_LIGHT_SHIFT: cfg_prdata = {24'b0, light_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  // shift in hundredths scaled to fractional units, truncated toward zero
  logic signed [7:0]         sh_raw [0:2];
  logic [7:0]                sh_mag [0:2];
  logic [FRAC_BITS+15:0]     sh_prod [0:2];
  logic signed [TW-1:0]      term_nxt [0:2];
  logic signed [TW-1:0]      term_r [0:2];

  assign sh_raw[0] = hue_r;
  assign sh_raw[1] = sat_r;
  assign sh_raw[2] = light_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh_mag[i]   = sh_raw[i][7] ? 8'(-sh_raw[i]) : 8'(sh_raw[i]);
      sh_prod[i]  = (FRAC_BITS+16)'(sh_mag[i]) * (FRAC_BITS+16)'(HK);
      term_nxt[i] = sh_raw[i][7] ? -TW'(sh_prod[i][FRAC_BITS+15:KSH])
                                 : TW'(sh_prod[i][FRAC_BITS+15:KSH]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) term_r[i] <= '0;
    end else begin
      for (int i = 0; i < 3; i++) term_r[i] <= term_nxt[i];
    end
  end

  logic [CB-1:0] px_red, px_green, px_blue;

  rgbha_core #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_red     (in_tdata[CB-1:0]),
    .in_green   (in_tdata[2*CB-1:CB]),
    .in_blue    (in_tdata[3*CB-1:2*CB]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_red    (px_red),
    .out_green  (px_green),
    .out_blue   (px_blue),
    .offs       (off_r),
    .hue_term   (term_r[0]),
    .sat_term   (term_r[1]),
    .light_term (term_r[2])
  );

  always_comb begin
    out_tdata                  = '0;
    out_tdata[CB-1:0]          = px_red;
    out_tdata[2*CB-1:CB]       = px_green;
    out_tdata[3*CB-1:2*CB]     = px_blue;
  end

endmodule
`default_nettype wire
